@@ sv/assert_macros.svh @@
// Assertion macros shared by the vertex transform RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define VMT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define VMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ sv/vmt_pkg.sv @@
// Shared types and constants for the vertex matrix transform.
package vmt_pkg;
  localparam int NUM_REGS = 8;
  localparam int REG_WIDTH = 64;
  localparam int REG_IDX_WIDTH = 3;

  typedef enum logic [1:0] {
    MODE_POINT = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_PROJECT = 2'd2,
    MODE_SPARE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_SAT = 2'd1,
    ST_WZERO = 2'd2,
    ST_RSVD = 2'd3
  } status_t;
endpackage

@@ sv/vmt_column.sv @@
// One matrix column: three products, round-half-up sum, saturate; three stages.
module vmt_column import vmt_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic signed [COORD_WIDTH-1:0] vx,
  input  logic signed [COORD_WIDTH-1:0] vy,
  input  logic signed [COORD_WIDTH-1:0] vz,
  input  logic signed [COORD_WIDTH-1:0] m0,
  input  logic signed [COORD_WIDTH-1:0] m1,
  input  logic signed [COORD_WIDTH-1:0] m2,
  input  logic signed [COORD_WIDTH-1:0] m3,
  input  logic                          trans,
  output logic signed [COORD_WIDTH-1:0] res,
  output logic                          sat
);
  localparam int PW = 2 * COORD_WIDTH;
  localparam int SW = PW + 3;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (COORD_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] MINV = -(SW'(1) <<< (COORD_WIDTH - 1));

  logic signed [PW-1:0] p0, p1, p2;
  logic signed [SW-1:0] t3;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] shifted;
  logic signed [SW-1:0] tadd;

  assign tadd = trans ? (SW'(m3) <<< FRAC_BITS) : '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      p0 <= PW'(vx) * PW'(m0);
      p1 <= PW'(vy) * PW'(m1);
      p2 <= PW'(vz) * PW'(m2);
      t3 <= tadd + HALF;
      sum <= SW'(p0) + SW'(p1) + SW'(p2) + t3;
    end
  end

  assign shifted = sum >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (shifted > MAXV) begin
        res <= MAXV[COORD_WIDTH-1:0];
        sat <= 1'b1;
      end else if (shifted < MINV) begin
        res <= MINV[COORD_WIDTH-1:0];
        sat <= 1'b1;
      end else begin
        res <= shifted[COORD_WIDTH-1:0];
        sat <= 1'b0;
      end
    end
  end
endmodule

@@ sv/vmt_div.sv @@
// Pipelined signed restoring divider, one quotient bit per stage.
module vmt_div #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic signed [COORD_WIDTH-1:0] num,
  input  logic signed [COORD_WIDTH-1:0] den,
  output logic signed [COORD_WIDTH-1:0] quo,
  output logic                          sat
);
  localparam int NW = COORD_WIDTH + FRAC_BITS;
  localparam int NS = NW + 1;
  localparam int DW = COORD_WIDTH + 1;

  logic [NW-1:0] nmag [NS];
  logic [NW-1:0] qbits [NS];
  logic [DW-1:0] rem [NS];
  logic [DW-1:0] dmag [NS];
  logic          neg [NS];

  logic [NW-1:0] nabs;
  logic [DW-1:0] dabs;
  assign nabs = num[COORD_WIDTH-1] ? NW'(-(NW'(signed'(num)) <<< FRAC_BITS))
                                   : NW'(NW'(signed'(num)) <<< FRAC_BITS);
  assign dabs = den[COORD_WIDTH-1] ? DW'(-DW'(signed'(den))) : DW'(signed'(den));

  always_ff @(posedge clk) begin
    if (adv) begin
      nmag[0] <= nabs;
      qbits[0] <= '0;
      rem[0] <= '0;
      dmag[0] <= dabs;
      neg[0] <= num[COORD_WIDTH-1] ^ den[COORD_WIDTH-1];
    end
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0] trial;
    assign trial = {rem[s], nmag[s][NW-1]} - {1'b0, dmag[s]};
    always_ff @(posedge clk) begin
      if (adv) begin
        nmag[s+1] <= nmag[s] << 1;
        dmag[s+1] <= dmag[s];
        neg[s+1] <= neg[s];
        if (!trial[DW]) begin
          rem[s+1] <= trial[DW-1:0];
          qbits[s+1] <= {qbits[s][NW-2:0], 1'b1};
        end else begin
          rem[s+1] <= {rem[s][DW-2:0], nmag[s][NW-1]};
          qbits[s+1] <= {qbits[s][NW-2:0], 1'b0};
        end
      end
    end
  end

  localparam logic [NW:0] MAXP = (NW+1)'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
  localparam logic [NW:0] MAXN = (NW+1)'(64'd1 << (COORD_WIDTH - 1));
  logic [NW:0] qm;
  assign qm = {1'b0, qbits[NW]};

  always_comb begin
    sat = 1'b0;
    if (neg[NW]) begin
      if (qm > MAXN) begin
        quo = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        sat = 1'b1;
      end else begin
        quo = COORD_WIDTH'(-qm);
      end
    end else begin
      if (qm > MAXP) begin
        quo = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        sat = 1'b1;
      end else begin
        quo = qm[COORD_WIDTH-1:0];
      end
    end
  end
endmodule

@@ sv/vertex_matrix_transform.sv @@
// Path to the output register: column units, divider input and bit stages, output register.
// Throughput: one vertex per cycle while the output is not stalled; every stage, divider bits included, is pipelined.
// A stall on the output while out_valid is high holds the whole pipeline; the input stalls only then.
// Reset: rst clears valid bits and loads the identity matrix.
// Vertex matrix transform top level: config registers, column units, divider, output.
`include "assert_macros.svh"
module vertex_matrix_transform import vmt_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [REG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [REG_WIDTH-1:0]       cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 mode,
  input  logic signed [31:0]         in_x,
  input  logic signed [31:0]         in_y,
  input  logic signed [31:0]         in_z,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         out_x,
  output logic signed [31:0]         out_y,
  output logic signed [31:0]         out_z,
  output logic [1:0]                 status
);
  localparam int CW = COORD_WIDTH;
  localparam int DEPTH = 3 + CW + FRAC_BITS + 1;
  localparam logic [REG_WIDTH-1:0] ONE = REG_WIDTH'(1) << FRAC_BITS;

  logic [REG_WIDTH-1:0] mreg [NUM_REGS];
  logic                 adv;
  logic [DEPTH-1:0]     vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      mreg[0] <= ONE;
      mreg[1] <= '0;
      mreg[2] <= ONE << 32;
      mreg[3] <= '0;
      mreg[4] <= '0;
      mreg[5] <= ONE;
      mreg[6] <= '0;
      mreg[7] <= ONE << 32;
    end else if (cfg_we) begin
      mreg[cfg_index] <= cfg_data;
    end
  end

  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic signed [CW-1:0] ent [4][4];
  for (genvar r = 0; r < 4; r++) begin : g_r
    for (genvar c = 0; c < 4; c++) begin : g_c
      assign ent[r][c] = mreg[r*2 + c/2][(c%2)*32 +: CW];
    end
  end

  logic trans;
  assign trans = (mode != MODE_NORMAL);

  logic signed [CW-1:0] col [4];
  logic                 csat [4];
  for (genvar c = 0; c < 4; c++) begin : g_col
    vmt_column #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(CW)) u_col (
      .clk(clk), .adv(adv),
      .vx(in_x[CW-1:0]), .vy(in_y[CW-1:0]), .vz(in_z[CW-1:0]),
      .m0(ent[0][c]), .m1(ent[1][c]), .m2(ent[2][c]), .m3(ent[3][c]),
      .trans(trans), .res(col[c]), .sat(csat[c])
    );
  end

  // mode travels with the column pipeline (3 stages)
  logic proj_p [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      proj_p[0] <= (mode == MODE_PROJECT);
      proj_p[1] <= proj_p[0];
      proj_p[2] <= proj_p[1];
    end
  end

  logic signed [CW-1:0] quo [3];
  logic                 qsat [3];
  for (genvar c = 0; c < 3; c++) begin : g_div
    vmt_div #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div (
      .clk(clk), .adv(adv), .num(col[c]), .den(col[3]),
      .quo(quo[c]), .sat(qsat[c])
    );
  end

  localparam int DL = CW + FRAC_BITS + 1;
  logic signed [CW-1:0] dres [DL][3];
  logic                 dproj [DL];
  logic                 dwz [DL];
  logic                 dflag [DL];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) dres[0][c] <= col[c];
      dproj[0] <= proj_p[2];
      dwz[0] <= (col[3] == '0);
      dflag[0] <= csat[0] | csat[1] | csat[2] | (proj_p[2] & csat[3]);
      for (int s = 1; s < DL; s++) begin
        dres[s] <= dres[s-1];
        dproj[s] <= dproj[s-1];
        dwz[s] <= dwz[s-1];
        dflag[s] <= dflag[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_valid};
      out_valid <= vld[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dproj[DL-1] && dwz[DL-1]) begin
        out_x <= '0;
        out_y <= '0;
        out_z <= '0;
        status <= ST_WZERO;
      end else if (dproj[DL-1]) begin
        out_x <= 32'(quo[0]);
        out_y <= 32'(quo[1]);
        out_z <= 32'(quo[2]);
        status <= (dflag[DL-1] | qsat[0] | qsat[1] | qsat[2]) ? ST_SAT : ST_OK;
      end else begin
        out_x <= 32'(dres[DL-1][0]);
        out_y <= 32'(dres[DL-1][1]);
        out_z <= 32'(dres[DL-1][2]);
        status <= dflag[DL-1] ? ST_SAT : ST_OK;
      end
    end
  end

  `VMT_ASSERT_IMP(a_stall_only_when_full, clk, rst, in_stall, out_valid && out_stall, "input stall without output stall")
  `VMT_ASSERT_NEXT(a_hold_on_stall, clk, rst, out_valid && out_stall, out_valid && $stable(out_x) && $stable(status), "output beat changed under stall")
  `VMT_ASSERT_IMP(a_status_code, clk, rst, out_valid, status != ST_RSVD, "reserved status code")
endmodule
